/* sv/ptdba_pkg.sv */
// types and constants for the paged top-down bump allocator
// used by ptdba_ctrl, ptdba_dp and paged_top_down_bump_allocator; no dependencies
`timescale 1ns / 1ps

package ptdba_pkg;

   // fixed field widths of the request and response
   localparam int KIND_W   = 2;
   localparam int SIZE_W   = 32;
   localparam int ALIGN_W  = 33;
   localparam int MARK_W   = 21;
   localparam int ADDR_W   = 32;
   localparam int CSR_W    = 21;
   localparam int CSR_IDX_W = 3;

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC  = 2'd0,
      KIND_MARK   = 2'd1,
      KIND_REWIND = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_ENABLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_START   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_END     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_ENABLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_START  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_END    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARE       = 3'd6;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } ctl_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

endpackage

/* sv/paged_top_down_bump_allocator.sv */
// paged top-down bump allocator: one response per request; the request is captured
// on acceptance, computed in the execute state, and strobe and response are registered
// together; the controller holds busy in the execute state, so no new request is taken
// until it ends; the receiver cannot stall; synchronous reset clears the configuration,
// both tops and the controller state; depends on ptdba_pkg, ptdba_ctrl and ptdba_dp
`timescale 1ns / 1ps

module paged_top_down_bump_allocator #(
   parameter int PAGE_BITS     = 12,
   parameter int PAGE_NUM_BITS = 21
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ptdba_pkg::KIND_W-1:0]    req_kind,
   input  logic                            req_heap_select,
   input  logic [ptdba_pkg::SIZE_W-1:0]    req_size_bytes,
   input  logic [ptdba_pkg::ALIGN_W-1:0]   req_align_bytes,
   input  logic [ptdba_pkg::MARK_W-1:0]    req_mark_page,
   output logic                            rsp_valid,
   output logic                            rsp_ok,
   output logic [ptdba_pkg::ADDR_W-1:0]    rsp_alloc_byte_addr,
   output logic [ptdba_pkg::MARK_W-1:0]    rsp_mark_value,
   input  logic                            csr_we,
   input  logic [ptdba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ptdba_pkg::CSR_W-1:0]     csr_wdata
);
   import ptdba_pkg::*;

   dp_cmd_type cmd;

   // request sequencing
   ptdba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   // config, top pointers and compute
   ptdba_dp #(
      .PAGE_BITS     (PAGE_BITS),
      .PAGE_NUM_BITS (PAGE_NUM_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_kind            (req_kind),
      .req_heap_select     (req_heap_select),
      .req_size_bytes      (req_size_bytes),
      .req_align_bytes     (req_align_bytes),
      .req_mark_page       (req_mark_page),
      .rsp_ok              (rsp_ok),
      .rsp_alloc_byte_addr (rsp_alloc_byte_addr),
      .rsp_mark_value      (rsp_mark_value)
   );

endmodule

/* sv/ptdba_ctrl.sv */
// controller for the paged top-down bump allocator: request sequencing and strobe
// depends on ptdba_pkg
`timescale 1ns / 1ps

module ptdba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output ptdba_pkg::dp_cmd_type cmd,
   output logic                  rsp_valid
);
   import ptdba_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   assign accept = start && (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response strobe follows the execute cycle
   assign rsp_valid_in = (state_ff == ST_EXEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign cmd.capture = accept;
   assign cmd.execute = (state_ff == ST_EXEC);
   assign rsp_valid   = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not enter execute");
   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_valid))
      else $error("execute did not finish with a response strobe");
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while still busy");
`endif

endmodule

/* sv/ptdba_dp.sv */
// datapath for the paged top-down bump allocator: config, top pointers, compute
// depends on ptdba_pkg
`timescale 1ns / 1ps

module ptdba_dp #(
   parameter int PAGE_BITS     = 12,
   parameter int PAGE_NUM_BITS = 21
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ptdba_pkg::dp_cmd_type                cmd,
   input  logic                                 csr_we,
   input  logic [ptdba_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptdba_pkg::CSR_W-1:0]          csr_wdata,
   input  logic [ptdba_pkg::KIND_W-1:0]         req_kind,
   input  logic                                 req_heap_select,
   input  logic [ptdba_pkg::SIZE_W-1:0]         req_size_bytes,
   input  logic [ptdba_pkg::ALIGN_W-1:0]        req_align_bytes,
   input  logic [ptdba_pkg::MARK_W-1:0]         req_mark_page,
   output logic                                 rsp_ok,
   output logic [ptdba_pkg::ADDR_W-1:0]         rsp_alloc_byte_addr,
   output logic [ptdba_pkg::MARK_W-1:0]         rsp_mark_value
);
   import ptdba_pkg::*;

   localparam int PNB     = PAGE_NUM_BITS;
   localparam int PAGES_W = ALIGN_W - PAGE_BITS;
   localparam int CMP_W   = (PNB > PAGES_W) ? PNB : PAGES_W;

   // configuration registers and top pointers
   logic           low_en_ff, high_en_ff, share_ff;
   logic [PNB-1:0] low_start_ff, low_end_ff, high_start_ff, high_end_ff;
   logic [PNB-1:0] low_top_ff, low_top_in, high_top_ff, high_top_in;

   // captured request
   logic [KIND_W-1:0]  kind_ff;
   logic               sel_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [ALIGN_W-1:0] align_ff;
   logic [MARK_W-1:0]  mark_ff;

   // response payload
   logic              ok_ff, ok_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [MARK_W-1:0] mval_ff, mval_in;

   // compute signals
   logic [PNB+CSR_W-1:0]      wdata_ext;
   logic [PNB-1:0]            wdata_page;
   logic                      use_high, enabled;
   logic [PNB-1:0]            start_sel, end_sel, top_sel, top_new;
   logic                      top_wr;
   logic [ALIGN_W-1:0]        size_round, align_m1;
   logic [PAGES_W-1:0]        pages, amask;
   logic [CMP_W-1:0]          top_cmp, pages_cmp, diff;
   logic [PNB+PAGES_W-1:0]    amask_ext;
   logic [PNB-1:0]            page;
   logic                      fits;
   logic [PNB+PAGE_BITS+ADDR_W-1:0] addr_wide;
   logic [PNB+MARK_W-1:0]     top_ext, mark_ext;
   logic [PNB-1:0]            mark_pg;

   // config write data held to page-number width
   assign wdata_ext  = {{PNB{1'b0}}, csr_wdata};
   assign wdata_page = wdata_ext[PNB-1:0];

   // heap selection; a shared segment uses the low top for both heaps
   assign use_high  = sel_ff && !share_ff;
   assign enabled   = sel_ff ? high_en_ff : low_en_ff;
   assign start_sel = sel_ff ? high_start_ff : low_start_ff;
   assign end_sel   = sel_ff ? high_end_ff : low_end_ff;
   assign top_sel   = use_high ? high_top_ff : low_top_ff;

   // alloc: round up to pages, subtract, clear alignment bits
   assign size_round = {1'b0, size_ff} + ALIGN_W'((64'd1 << PAGE_BITS) - 64'd1);
   assign pages      = size_round[ALIGN_W-1:PAGE_BITS];
   assign top_cmp    = CMP_W'(top_sel);
   assign pages_cmp  = CMP_W'(pages);
   assign fits       = (pages_cmp <= top_cmp);
   assign diff       = top_cmp - pages_cmp;
   assign align_m1   = align_ff - ALIGN_W'(1);
   assign amask      = align_m1[ALIGN_W-1:PAGE_BITS];
   assign amask_ext  = {{PNB{1'b0}}, amask};
   assign page       = diff[PNB-1:0] & ~amask_ext[PNB-1:0];
   assign addr_wide  = {{(PAGE_BITS+ADDR_W){1'b0}}, page} << PAGE_BITS;

   // mark and rewind views of the page numbers
   assign top_ext  = {{MARK_W{1'b0}}, top_sel};
   assign mark_ext = {{PNB{1'b0}}, mark_ff};
   assign mark_pg  = mark_ext[PNB-1:0];

   // request result and top update
   always_comb begin
      ok_in   = 1'b0;
      addr_in = '0;
      mval_in = '0;
      top_wr  = 1'b0;
      top_new = top_sel;
      if (enabled) begin
         case (kind_type'(kind_ff))
            KIND_ALLOC: begin
               if (fits && (page >= start_sel)) begin
                  ok_in   = 1'b1;
                  addr_in = addr_wide[ADDR_W-1:0];
                  top_wr  = 1'b1;
                  top_new = page;
               end
            end
            KIND_MARK: begin
               ok_in   = 1'b1;
               mval_in = top_ext[MARK_W-1:0];
            end
            KIND_REWIND: begin
               if ((mark_pg > top_sel) && (mark_pg <= end_sel)) begin
                  ok_in   = 1'b1;
                  top_wr  = 1'b1;
                  top_new = mark_pg;
               end
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   // top pointer next values: end writes reload, executes update
   always_comb begin
      low_top_in  = low_top_ff;
      high_top_in = high_top_ff;
      if (csr_we && (csr_index == CSR_LOW_END)) begin
         low_top_in = wdata_page;
      end else if (csr_we && (csr_index == CSR_HIGH_END)) begin
         high_top_in = wdata_page;
      end else if (cmd.execute && top_wr) begin
         if (use_high) high_top_in = top_new;
         else          low_top_in  = top_new;
      end
   end

   // configuration registers and tops
   always_ff @(posedge clock) begin
      if (reset) begin
         low_en_ff     <= 1'b0;
         high_en_ff    <= 1'b0;
         share_ff      <= 1'b0;
         low_start_ff  <= '0;
         low_end_ff    <= '0;
         high_start_ff <= '0;
         high_end_ff   <= '0;
         low_top_ff    <= '0;
         high_top_ff   <= '0;
      end else begin
         low_top_ff  <= low_top_in;
         high_top_ff <= high_top_in;
         if (csr_we) begin
            case (csr_index)
               CSR_LOW_ENABLE:  low_en_ff     <= csr_wdata[0];
               CSR_LOW_START:   low_start_ff  <= wdata_page;
               CSR_LOW_END:     low_end_ff    <= wdata_page;
               CSR_HIGH_ENABLE: high_en_ff    <= csr_wdata[0];
               CSR_HIGH_START:  high_start_ff <= wdata_page;
               CSR_HIGH_END:    high_end_ff   <= wdata_page;
               CSR_SHARE:       share_ff      <= csr_wdata[0];
               default:         share_ff      <= share_ff;
            endcase
         end
      end
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         sel_ff   <= req_heap_select;
         size_ff  <= req_size_bytes;
         align_ff <= req_align_bytes;
         mark_ff  <= req_mark_page;
      end
      if (cmd.execute) begin
         ok_ff   <= ok_in;
         addr_ff <= addr_in;
         mval_ff <= mval_in;
      end
   end

   assign rsp_ok              = ok_ff;
   assign rsp_alloc_byte_addr = addr_ff;
   assign rsp_mark_value      = mval_ff;

`ifndef SYNTHESIS
   a_fail_zero_payload: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (ok_ff || ((addr_ff == '0) && (mval_ff == '0))))
      else $error("failed request carries a nonzero payload");
   a_disabled_keeps_top: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && !enabled && !csr_we) |=>
         ($stable(low_top_ff) && $stable(high_top_ff)))
      else $error("disabled heap moved a top pointer");
`endif

endmodule

/* tb/testbench.sv */
// self-checking testbench for paged_top_down_bump_allocator: directed and random requests
// with a scoreboard that predicts every response; depends on ptdba_pkg and the block itself
`timescale 1ns / 1ps

module testbench;
   import ptdba_pkg::*;

   localparam int PAGE_BITS = 12;

   typedef struct {
      logic              ok;
      logic [ADDR_W-1:0] addr;
      logic [MARK_W-1:0] mval;
   } alloc_result_type;

   // predicts allocator responses from its own copy of the registers and tops
   class alloc_scoreboard;
      logic              low_en, high_en, share;
      logic [CSR_W-1:0]  low_start, low_end, high_start, high_end;
      logic [MARK_W-1:0] low_top, high_top;
      alloc_result_type  want_q[$];
      int                errors;

      function new();
         low_en = 1'b0;
         high_en = 1'b0;
         share = 1'b0;
         low_start = '0;
         low_end = '0;
         high_start = '0;
         high_end = '0;
         low_top = '0;
         high_top = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_LOW_ENABLE:  low_en = val[0];
            CSR_LOW_START:   low_start = val;
            CSR_LOW_END: begin
               low_end = val;
               low_top = val;
            end
            CSR_HIGH_ENABLE: high_en = val[0];
            CSR_HIGH_START:  high_start = val;
            CSR_HIGH_END: begin
               high_end = val;
               high_top = val;
            end
            CSR_SHARE:       share = val[0];
            default: ;
         endcase
      endfunction

      // top pointer a heap works on; a shared segment always uses the low top
      function logic [MARK_W-1:0] top_page(logic sel);
         return (sel && !share) ? high_top : low_top;
      endfunction

      function int pending();
         return want_q.size();
      endfunction

      function void note_request(kind_type kind, logic sel, logic [SIZE_W-1:0] size,
                                 logic [ALIGN_W-1:0] align, logic [MARK_W-1:0] mark);
         alloc_result_type  r;
         logic [63:0]       pages, page, amask, byte_addr;
         logic [ALIGN_W-1:0] align_m1;
         logic [MARK_W-1:0] top, start_pg, end_pg;
         logic              enabled;
         r.ok = 1'b0;
         r.addr = '0;
         r.mval = '0;
         enabled = sel ? high_en : low_en;
         start_pg = sel ? high_start : low_start;
         end_pg = sel ? high_end : low_end;
         top = top_page(sel);
         if (enabled) begin
            case (kind)
               KIND_ALLOC: begin
                  pages = ({32'd0, size} + (64'd1 << PAGE_BITS) - 64'd1) >> PAGE_BITS;
                  // a request larger than the top fails instead of wrapping
                  if (pages <= {43'd0, top}) begin
                     align_m1 = align - 33'd1;
                     amask = {31'd0, align_m1} >> PAGE_BITS;
                     page = ({43'd0, top} - pages) & ~amask;
                     if (page >= {43'd0, start_pg}) begin
                        top = page[MARK_W-1:0];
                        byte_addr = page << PAGE_BITS;
                        r.ok = 1'b1;
                        r.addr = byte_addr[ADDR_W-1:0];
                     end
                  end
               end
               KIND_MARK: begin
                  r.ok = 1'b1;
                  r.mval = top;
               end
               KIND_REWIND: begin
                  if (mark > top && mark <= end_pg) begin
                     top = mark;
                     r.ok = 1'b1;
                  end
               end
               default: ;
            endcase
            if (sel && !share) high_top = top;
            else low_top = top;
         end
         want_q.push_back(r);
      endfunction

      function void check_response(logic ok, logic [ADDR_W-1:0] addr, logic [MARK_W-1:0] mval);
         alloc_result_type w;
         if (want_q.size() == 0) begin
            $display("%0t unexpected response: ok %0d addr %h mark %h", $time, ok, addr, mval);
            errors++;
            return;
         end
         w = want_q.pop_front();
         if (ok !== w.ok) begin
            $display("%0t rsp_ok mismatch: expected %0d actual %0d", $time, w.ok, ok);
            errors++;
         end
         if (addr !== w.addr) begin
            $display("%0t rsp_alloc_byte_addr mismatch: expected %h actual %h",
                     $time, w.addr, addr);
            errors++;
         end
         if (mval !== w.mval) begin
            $display("%0t rsp_mark_value mismatch: expected %h actual %h", $time, w.mval, mval);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [KIND_W-1:0]    req_kind;
   logic                 req_heap_select;
   logic [SIZE_W-1:0]    req_size_bytes;
   logic [ALIGN_W-1:0]   req_align_bytes;
   logic [MARK_W-1:0]    req_mark_page;
   logic                 rsp_valid;
   logic                 rsp_ok;
   logic [ADDR_W-1:0]    rsp_alloc_byte_addr;
   logic [MARK_W-1:0]    rsp_mark_value;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   alloc_scoreboard sb;
   int              sender_idle_pct;

   paged_top_down_bump_allocator u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_heap_select     (req_heap_select),
      .req_size_bytes      (req_size_bytes),
      .req_align_bytes     (req_align_bytes),
      .req_mark_page       (req_mark_page),
      .rsp_valid           (rsp_valid),
      .rsp_ok              (rsp_ok),
      .rsp_alloc_byte_addr (rsp_alloc_byte_addr),
      .rsp_mark_value      (rsp_mark_value),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // note accepted requests and check responses at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_request(kind_type'(req_kind), req_heap_select, req_size_bytes,
                            req_align_bytes, req_mark_page);
         if (rsp_valid)
            sb.check_response(rsp_ok, rsp_alloc_byte_addr, rsp_mark_value);
      end
   end

   // present one request at a falling edge, hold it until accepted, then maybe idle
   task automatic send_request(kind_type k, logic sel, logic [SIZE_W-1:0] size,
                               logic [ALIGN_W-1:0] align, logic [MARK_W-1:0] mark);
      start <= 1'b1;
      req_kind <= k;
      req_heap_select <= sel;
      req_size_bytes <= size;
      req_align_bytes <= align;
      req_mark_page <= mark;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
   endtask

   // drop start and wait for all outstanding responses plus a few cycles
   task automatic wait_drained();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (sb.pending() != 0 && waited < 500) begin
         @(negedge clock);
         waited++;
      end
      repeat (6) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   // program every register; only called while the block is idle
   task automatic apply_config(logic len, int lstart, int lend, logic hen, int hstart,
                               int hend, logic sh);
      csr_write(CSR_LOW_ENABLE, CSR_W'(len));
      csr_write(CSR_LOW_START, CSR_W'(lstart));
      csr_write(CSR_LOW_END, CSR_W'(lend));
      csr_write(CSR_HIGH_ENABLE, CSR_W'(hen));
      csr_write(CSR_HIGH_START, CSR_W'(hstart));
      csr_write(CSR_HIGH_END, CSR_W'(hend));
      csr_write(CSR_SHARE, CSR_W'(sh));
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // mostly a handful of pages, sometimes large or full-range sizes
   function automatic logic [SIZE_W-1:0] rand_size();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return $urandom_range(0, 8 * 4096);
         6:       return $urandom_range(0, 64) * 4096;
         7:       return $urandom;
         8:       return '0;
         default: return $urandom_range(0, 400) * 4096 + $urandom_range(0, 4095);
      endcase
   endfunction

   // mostly powers of two, sometimes zero or arbitrary values
   function automatic logic [ALIGN_W-1:0] rand_align();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: return 33'd1 << $urandom_range(0, 16);
         7:       return 33'd1 << $urandom_range(0, 32);
         8:       return {1'($urandom_range(0, 1)), 32'($urandom)};
         default: return '0;
      endcase
   endfunction

   // mark / alloc / rewind sequences on one heap, mixed with single random requests
   task automatic run_random(int count);
      int                done, n;
      logic              sel;
      logic [MARK_W-1:0] saved, tgt;
      done = 0;
      while (done < count) begin
         sel = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 99) < 70) begin
            saved = sb.top_page(sel);
            send_request(KIND_MARK, sel, $urandom, rand_align(), MARK_W'($urandom));
            n = $urandom_range(1, 6);
            repeat (n) send_request(KIND_ALLOC, sel, rand_size(), rand_align(), MARK_W'($urandom));
            if ($urandom_range(0, 3) != 0)
               send_request(KIND_REWIND, sel, $urandom, rand_align(), saved);
            done += n + 2;
         end else begin
            case ($urandom_range(0, 7))
               0, 1, 2, 3: tgt = sb.top_page(sel) + MARK_W'($urandom_range(1, 40));
               4:       tgt = sb.top_page(sel) - MARK_W'($urandom_range(0, 5));
               5:       tgt = (sel ? sb.high_end : sb.low_end) + MARK_W'($urandom_range(0, 1));
               default: tgt = MARK_W'($urandom);
            endcase
            send_request(kind_type'($urandom_range(0, 3)), sel, rand_size(), rand_align(), tgt);
            done++;
         end
      end
   endtask

   // run limit
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int   idle_by_phase[3];
      int   lstart, lend, hstart, hend, span;
      logic len, hen, sh;
      idle_by_phase = '{6, 86, 0};
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_ALLOC;
      req_heap_select = 1'b0;
      req_size_bytes = '0;
      req_align_bytes = 33'd1;
      req_mark_page = '0;
      csr_we = 1'b0;
      csr_index = CSR_LOW_ENABLE;
      csr_wdata = '0;
      sender_idle_pct = idle_by_phase[0];
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // full-range low heap, small high heap, separate tops
      apply_config(1'b1, 0, 1048576, 1'b1, 100, 200, 1'b0);
      send_request(KIND_MARK, 1'b0, '0, 33'd1, '0);
      // zero bytes at the very top: byte address is cut to 32 bits
      send_request(KIND_ALLOC, 1'b0, '0, 33'd1, '0);
      send_request(KIND_ALLOC, 1'b0, 32'd1, 33'd1, '0);
      // huge request larger than the top
      send_request(KIND_ALLOC, 1'b0, 32'hFFFF_FFFF, 33'h1_0000_0000, '0);
      // alignment of zero clears every page bit
      send_request(KIND_ALLOC, 1'b0, 32'd4096, '0, '0);
      send_request(KIND_REWIND, 1'b0, '0, 33'd1, 21'd1048576);
      // rewind not above the top, then above the heap end
      send_request(KIND_REWIND, 1'b0, '0, 33'd1, 21'd1048576);
      send_request(KIND_REWIND, 1'b0, '0, 33'd1, 21'h1F_FFFF);
      send_request(KIND_ALLOC, 1'b1, 32'd204800, 33'd65536, '0);
      // falls below the heap start
      send_request(KIND_ALLOC, 1'b1, 32'd409600, 33'd1, '0);
      // alignment that is not a power of two
      send_request(KIND_ALLOC, 1'b1, 32'd4096, 33'd12288, '0);
      send_request(KIND_NONE, 1'b0, '1, '1, '1);
      send_request(KIND_MARK, 1'b1, '1, '1, '1);
      send_request(KIND_REWIND, 1'b1, '0, 33'd1, 21'd200);
      send_request(KIND_ALLOC, 1'b1, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF, 21'h1F_FFFF);
      wait_drained();

      // shared segment with the low heap disabled
      apply_config(1'b0, 5, 300, 1'b1, 10, 400, 1'b1);
      send_request(KIND_MARK, 1'b0, '0, 33'd1, '0);
      send_request(KIND_ALLOC, 1'b0, 32'd4096, 33'd1, '0);
      send_request(KIND_REWIND, 1'b0, '0, 33'd1, 21'd299);
      send_request(KIND_MARK, 1'b1, '0, 33'd1, '0);
      send_request(KIND_ALLOC, 1'b1, 32'd8192, 33'd1, '0);
      send_request(KIND_REWIND, 1'b1, '0, 33'd1, 21'd400);
      send_request(KIND_MARK, 1'b1, '0, 33'd1, '0);
      wait_drained();

      // random phases: sender idles rarely, then often, then never
      for (int p = 0; p < 3; p++) begin
         sender_idle_pct = idle_by_phase[p];
         for (int c = 0; c < 4; c++) begin
            if (p == 0 && c == 0) begin
               apply_config(1'b1, 0, 1048576, 1'b1, 0, 1048576, 1'($urandom_range(0, 1)));
            end else if (p == 1 && c == 0) begin
               apply_config(1'b1, 0, 0, 1'b1, 0, 0, 1'b0);
            end else begin
               lend = $urandom_range(0, 1048576);
               span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5000) : $urandom_range(0, 200);
               lstart = (lend > span) ? lend - span : 0;
               if ($urandom_range(0, 9) == 0) lstart = $urandom_range(0, 1048576);
               hend = $urandom_range(0, 1048576);
               span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5000) : $urandom_range(0, 200);
               hstart = (hend > span) ? hend - span : 0;
               if ($urandom_range(0, 9) == 0) hstart = $urandom_range(0, 1048576);
               len = ($urandom_range(0, 9) != 0);
               hen = ($urandom_range(0, 9) != 0);
               sh = ($urandom_range(0, 2) == 0);
               // a shared segment gets the same bounds for both heaps about half of the time
               if (sh && $urandom_range(0, 1) == 1) begin
                  hstart = lstart;
                  hend = lend;
               end
               apply_config(len, lstart, lend, hen, hstart, hend, sh);
            end
            run_random(72);
            wait_drained();
         end
      end

      if (sb.pending() != 0) begin
         $display("%0t %0d responses never arrived", $time, sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/ptdba_pkg.sv
sv/ptdba_ctrl.sv
sv/ptdba_dp.sv
sv/paged_top_down_bump_allocator.sv
tb/testbench.sv
